/* hw/rtl/qsv_pkg.sv */
package qsv_pkg;

    // Default limit on the value length, in bytes.
    localparam int MAX_LENGTH_DEF = 4096;

    // Width of the offset and length fields on the result channel.
    localparam int OUT_POS_W = 13;

    // Byte codes with a special meaning.
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_BSLASH = 8'd92;

    // Scan phase: leading whitespace, then the value itself.
    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_VALUE = 2'd1
    } t_phase;

    // One input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    // One verdict.
    typedef struct packed {
        logic                 valid_res;
        logic                 was_quoted;
        logic [OUT_POS_W-1:0] value_offset;
        logic [OUT_POS_W-1:0] value_length;
    } t_result;

    // Running state of the content check.
    typedef struct packed {
        logic       escape_pending;
        logic [2:0] cont_left;
        logic       error_flag;
        logic       stopped_by_nul;
    } t_content;

    // Whitespace: HT, LF, VT, FF, CR and space.
    function automatic logic is_space(input logic [7:0] b);
        return (b inside {[8'd9:8'd13], 8'd32});
    endfunction

    // Quoted-string text, plus space and tab.
    function automatic logic is_text(input logic [7:0] b);
        return (b inside {8'd9, 8'd32, 8'd33, [8'd35:8'd91], [8'd93:8'd126]});
    endfunction

    // Number of continuation bytes that a UTF-8 lead byte announces.
    function automatic logic [2:0] lead_count(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b inside {[8'd192:8'd223]}) begin
            n = 3'd1;
        end else if (b inside {[8'd224:8'd239]}) begin
            n = 3'd2;
        end else if (b inside {[8'd240:8'd247]}) begin
            n = 3'd3;
        end else if (b inside {[8'd248:8'd251]}) begin
            n = 3'd4;
        end else if (b inside {[8'd252:8'd253]}) begin
            n = 3'd5;
        end
        return n;
    endfunction

    // Advances the content check by one byte.
    function automatic t_content check_content(input logic [7:0] b, input t_content c);
        t_content r;
        r = c;
        if (!c.stopped_by_nul && !c.error_flag) begin
            if (c.cont_left != 3'd0) begin
                // Inside a UTF-8 sequence: only continuation bytes may follow.
                if (b inside {[8'd128:8'd191]}) begin
                    r.cont_left = c.cont_left - 3'd1;
                end else begin
                    r.error_flag = 1'b1;
                    r.cont_left  = 3'd0;
                end
            end else if (c.escape_pending) begin
                // Escaped byte: any 7-bit code except a line break.
                r.escape_pending = 1'b0;
                if (b[7] || b == CH_LF || b == CH_CR) begin
                    r.error_flag = 1'b1;
                end
            end else if (b == CH_NUL) begin
                r.stopped_by_nul = 1'b1;
            end else if (b inside {[8'd192:8'd253]}) begin
                r.cont_left = lead_count(b);
            end else if (b == CH_BSLASH) begin
                r.escape_pending = 1'b1;
            end else if (!is_text(b)) begin
                r.error_flag = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/qsv_in_stage.sv */
module qsv_in_stage
    import qsv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // last_byte
    input  logic       i_advance,
    output logic       o_item_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The register takes a new request when empty or when its content moves on.
    assign o_s_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // Payload carries no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.data_byte <= i_s_tdata;
            r_item.last_byte <= i_s_tlast;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* hw/rtl/qsv_scan.sv */
module qsv_scan
    import qsv_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  logic    i_quotes_required,
    output logic    o_res_valid,
    output t_result o_result
);

    // Positions saturate at MAX_LENGTH + 1.
    localparam int POS_W = $clog2(MAX_LENGTH + 2);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

    t_phase           r_phase,    n_phase;
    t_content         r_content,  n_content;
    logic             r_quoted,   n_quoted;
    logic [POS_W-1:0] r_byte_pos, n_byte_pos;
    logic [POS_W-1:0] r_start,    n_start;

    logic             too_long;
    logic             closing;
    logic             content_ok;
    logic [POS_W-1:0] span;
    t_result          res;

    // Per-byte state update and verdict.
    always_comb begin
        n_phase    = r_phase;
        n_content  = r_content;
        n_quoted   = r_quoted;
        n_start    = r_start;
        closing    = 1'b0;
        n_byte_pos = (r_byte_pos <= POS_MAX) ? r_byte_pos + POS_W'(1) : r_byte_pos;
        too_long   = n_byte_pos > POS_MAX;

        if (!too_long) begin
            case (r_phase)
                PH_SKIP: begin
                    if (!is_space(i_item.data_byte)) begin
                        n_phase = PH_VALUE;
                        n_start = r_byte_pos;
                        if (i_item.data_byte == CH_QUOTE) begin
                            n_quoted = 1'b1;
                        end else begin
                            n_content = check_content(i_item.data_byte, r_content);
                        end
                    end
                end
                PH_VALUE: begin
                    if (r_quoted && i_item.last_byte) begin
                        closing = (i_item.data_byte == CH_QUOTE);
                    end else begin
                        n_content = check_content(i_item.data_byte, r_content);
                    end
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end

        content_ok = !n_content.error_flag &&
                     (n_content.stopped_by_nul ||
                      (n_content.cont_left == 3'd0 && !n_content.escape_pending));
        span = n_byte_pos - n_start;

        // Verdict for the case where this byte ends the value.
        res = '0;
        if (too_long) begin
            res = '0;
        end else if (n_quoted && closing) begin
            res.valid_res    = content_ok;
            res.was_quoted   = 1'b1;
            res.value_offset = OUT_POS_W'(n_start + POS_W'(1));
            res.value_length = OUT_POS_W'(span - POS_W'(2));
        end else if (n_quoted) begin
            res.value_offset = OUT_POS_W'(n_start);
            res.value_length = OUT_POS_W'(span);
        end else if (n_phase == PH_SKIP) begin
            res.valid_res    = !i_quotes_required;
            res.value_offset = OUT_POS_W'(n_byte_pos);
        end else begin
            res.valid_res    = !i_quotes_required && content_ok;
            res.value_offset = OUT_POS_W'(n_start);
            res.value_length = OUT_POS_W'(span);
        end
    end

    // Scan state; the last byte of a value returns it to the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_phase    <= PH_SKIP;
            r_content  <= '0;
            r_quoted   <= 1'b0;
            r_byte_pos <= '0;
            r_start    <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_content  <= n_content;
            r_quoted   <= n_quoted;
            r_byte_pos <= n_byte_pos;
            r_start    <= n_start;
        end
    end

    assign o_res_valid = i_step && i_item.last_byte;
    assign o_result    = res;

endmodule

/* hw/rtl/qsv_out_stage.sv */
module qsv_out_stage
    import qsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_advance,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [12:0] value_offset, [25:13] value_length, rest zero
    output logic [1:0]  o_m_tuser   // [0] valid_res, [1] was_quoted
);

    logic    r_valid;
    t_result r_result;

    // The upstream stage may move whenever this register is free or being drained.
    assign o_advance = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'd0, r_result.value_length, r_result.value_offset};
    assign o_m_tuser  = {r_result.was_quoted, r_result.valid_res};

endmodule

/* hw/rtl/quoted_string_validator.sv */
// Quoted string validator.
// The input stream carries a header value one byte per request in s_tdata,
// with s_tlast high on the final byte. Leading whitespace is skipped, optional
// or required enclosing quotes are checked and stripped, and the content is
// checked for quoted text, backslash escapes and UTF-8 sequences.
// The output stream carries one verdict per value, issued for its last byte:
// m_tuser holds the valid and quoted flags, m_tdata the offset and length.
// The cfg write port sets the quotes-required register (reset value 1); the user
// must write it only while no value is in flight; the block does not enforce this.
// Throughput: one byte per cycle, sustained while the receiver does not stall, back to back across values.
// Each byte is held in the input register and scanned combinationally; the
// verdict for a last byte is then registered in the result register, which
// presents it to the receiver.
// When the receiver stalls, the result register holds the verdict; bytes that
// end no value keep flowing, and the input side stalls only when a second
// verdict is ready behind the held one.
// Synchronous reset clears the scan state and both stage valid bits.
module quoted_string_validator
    import qsv_pkg::*;
#(
    parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_byte
    input  logic        i_s_tlast,  // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [12:0] value_offset, [25:13] value_length, rest zero
    output logic [1:0]  o_m_tuser,  // [0] valid_res, [1] was_quoted
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    logic    r_quotes_required;
    logic    advance;
    logic    item_go;
    logic    item_valid;
    t_item   item;
    logic    res_valid;
    t_result result;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quotes_required <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_quotes_required <= i_cfg_wr_data;
        end
    end

    // Only a byte that ends a value needs room in the result register.
    assign item_go = advance || !item.last_byte;

    qsv_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_advance    (item_go),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    qsv_scan #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_scan (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (item_valid && item_go),
        .i_item            (item),
        .i_quotes_required (r_quotes_required),
        .o_res_valid       (res_valid),
        .o_result          (result)
    );

    qsv_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_result   (result),
        .o_advance  (advance),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
